>>> hw/rtl/rmst_pkg.sv
// Shared types and constants for the range-minimum sparse table core.
`timescale 1ns / 1ps

package rmst_pkg;

    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int LEN_W       = INDEX_W + 1;
    localparam int TOP_W       = 4;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_Q_LEVEL,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_MIN,
        S_EMIT
    } rmst_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } rmst_mem_ctl_t;

endpackage

>>> hw/rtl/rmst_table_mem.sv
// Window minima memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module rmst_table_mem
    import rmst_pkg::*;
#(
    parameter int ADDR_W = 14,
    parameter int DEPTH  = 11264
)
(
    input  logic                clk,
    input  rmst_mem_ctl_t       ctl,
    input  logic [ADDR_W-1:0]   waddr,
    input  logic [VALUE_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output logic [VALUE_W-1:0]  rdata
);

    logic [VALUE_W-1:0] mem [0:DEPTH-1];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rmst_min_unit.sv
// Shared signed minimum unit used by both the fill and the query sequences.
`timescale 1ns / 1ps

module rmst_min_unit
    import rmst_pkg::*;
(
    input  logic [VALUE_W-1:0] a,
    input  logic [VALUE_W-1:0] b,
    output logic [VALUE_W-1:0] y
);

    assign y = ($signed(a) <= $signed(b)) ? a : b;

endmodule

>>> hw/rtl/range_minimum_sparse_table_core.sv
// Top level: sequencer for sparse table fill and range-minimum query.
// Load into a table of n words: level 0, then levels 1 .. min(floor(log2(n + 1)), LEVELS - 1),
//   one level per cycle through the single memory read port and min unit; a dropped load stays idle.
// Query: Q_LEVEL, Q_RD0, Q_RD1, Q_MIN, then EMIT registers the word; a bad range goes to EMIT.
// A stalled result word holds the next query in its emit state; one word in flight.
// rst_n asynchronous, active low: clears the count and sequencer; table undefined until loaded.
`timescale 1ns / 1ps

module range_minimum_sparse_table_core
    import rmst_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] element_value, [41:32] left_index, [51:42] right_index, [55:52] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] min_value
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] range_error
    output logic                   m_tuser
);

    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int KW    = $clog2(LEVELS);
    localparam int WW    = (LEVELS > CW) ? LEVELS : CW;
    localparam int AW    = KW + IW;
    localparam int DEPTH = LEVELS * (2 ** IW);

    rmst_state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic [IW-1:0]      n_reg, n_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [WW-1:0]      span_reg, span_next;
    logic [VALUE_W-1:0] cur_reg, cur_next;
    logic [INDEX_W-1:0] lo_reg, lo_next;
    logic [INDEX_W-1:0] hi_reg, hi_next;
    logic [KW-1:0]      g_reg, g_next;
    logic [LEN_W-1:0]   second_reg, second_next;
    logic [VALUE_W-1:0] a_reg, a_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_err_reg, res_err_next;

    rmst_mem_ctl_t      mem_ctl;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;

    logic [VALUE_W-1:0] cmp_a;
    logic [VALUE_W-1:0] cmp_y;

    logic [VALUE_W-1:0] in_value;
    logic [INDEX_W-1:0] in_left;
    logic [INDEX_W-1:0] in_right;
    logic               in_fire;

    logic [WW-1:0]      n1;
    logic [WW-1:0]      span_up;
    logic [LEN_W-1:0]   q_len;
    logic [TOP_W-1:0]   q_top;
    logic [LEN_W-1:0]   hi1;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_left  = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];
    assign in_right = s_tdata[VALUE_W+2*INDEX_W-1:VALUE_W+INDEX_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign n1      = WW'(n_reg) + WW'(1);
    assign span_up = span_reg << 1;
    assign q_len   = LEN_W'(hi_reg) - LEN_W'(lo_reg) + LEN_W'(1);
    assign hi1     = LEN_W'(hi_reg) + LEN_W'(1);

    // highest set bit of the range length
    always_comb
    begin
        q_top = '0;
        for (int i = 0; i < LEN_W; i++)
        begin
            if (q_len[i])
            begin
                q_top = TOP_W'(i);
            end
        end
    end

    assign cmp_a = (state_reg == S_LOAD) ? cur_reg : a_reg;

    rmst_min_unit u_min (
        .a (cmp_a),
        .b (rdata),
        .y (cmp_y)
    );

    rmst_table_mem #(
        .ADDR_W (AW),
        .DEPTH  (DEPTH)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        span_next      = span_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        g_next         = g_reg;
        second_next    = second_reg;
        a_next         = a_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        mem_ctl        = '0;
        waddr          = '0;
        wdata          = cur_reg;
        raddr          = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == KIND_LOAD)
                    begin
                        if (count_reg < CW'(MAX_ELEMENTS))
                        begin
                            mem_ctl.wr_en = 1'b1;
                            waddr         = {KW'(0), IW'(count_reg)};
                            wdata         = in_value;
                            cur_next      = in_value;
                            n_next        = IW'(count_reg);
                            count_next    = count_reg + CW'(1);
                            k_next        = KW'(1);
                            span_next     = WW'(2);
                            if (count_reg != '0)
                            begin
                                // level 1 window starts one below the new index
                                mem_ctl.rd_en = 1'b1;
                                raddr         = {KW'(0), IW'(count_reg - CW'(1))};
                                state_next    = S_LOAD;
                            end
                        end
                    end
                    else
                    begin
                        lo_next = in_left;
                        hi_next = in_right;
                        if (in_left > in_right || 32'(in_right) >= 32'(count_reg))
                        begin
                            res_value_next = '0;
                            res_err_next   = 1'b1;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_Q_LEVEL;
                        end
                    end
                end
            end

            S_LOAD:
            begin
                // rdata is level k-1 at the window start; cur is level k-1 ending at n
                mem_ctl.wr_en = 1'b1;
                waddr         = {k_reg, IW'(n1 - span_reg)};
                wdata         = cmp_y;
                cur_next      = cmp_y;
                if ((32'(k_reg) + 1 < LEVELS) && (span_up <= n1))
                begin
                    mem_ctl.rd_en = 1'b1;
                    raddr         = {k_reg, IW'(n1 - span_up)};
                    k_next        = KW'(32'(k_reg) + 1);
                    span_next     = span_up;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_Q_LEVEL:
            begin
                if (32'(q_top) > LEVELS - 1)
                begin
                    g_next = KW'(LEVELS - 1);
                end
                else
                begin
                    g_next = KW'(q_top);
                end
                state_next = S_Q_RD0;
            end

            S_Q_RD0:
            begin
                mem_ctl.rd_en = 1'b1;
                raddr         = {g_reg, IW'(lo_reg)};
                second_next   = hi1 - (LEN_W'(1) << g_reg);
                state_next    = S_Q_RD1;
            end

            S_Q_RD1:
            begin
                mem_ctl.rd_en = 1'b1;
                raddr         = {g_reg, IW'(second_reg)};
                a_next        = rdata;
                state_next    = S_Q_MIN;
            end

            S_Q_MIN:
            begin
                res_value_next = cmp_y;
                res_err_next   = 1'b0;
                state_next     = S_EMIT;
            end

            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = res_err_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        span_reg      <= span_next;
        cur_reg       <= cur_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        g_reg         <= g_next;
        second_reg    <= second_next;
        a_reg         <= a_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hw/rtl/rmst_checker.sv
// Port-level assertions for the range-minimum core, bound to the top level.
`timescale 1ns / 1ps

module rmst_checker
    import rmst_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // error words carry a zero minimum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error word with nonzero min_value");

    // a load never produces a result word
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_LOAD |=> !$rose(m_tvalid))
        else $error("result word after a load");

    // a query occupies the sequencer
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_QUERY |=> !s_tready)
        else $error("ready right after a query");

    // input word waiting for ready holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input word changed while waiting");

endmodule

bind range_minimum_sparse_table_core rmst_checker u_rmst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/range_minimum_sparse_table_core_test.sv
// Stream testbench for the range-minimum sparse table core: directed and random loads and queries, scoreboarded.
`timescale 1ns / 1ps

class min_scoreboard #(int DEPTH = 1024, int NLEVELS = 11);
    // [k][i]: minimum of elements i .. i + 2^k - 1
    logic [31:0] window_min [NLEVELS][DEPTH];
    int unsigned loaded;
    logic [32:0] expected_q [$];   // {range_error, min_value}
    int errors;

    function new();
        loaded = 0;
        errors = 0;
    endfunction

    function logic [31:0] smaller(logic [31:0] a, logic [31:0] b);
        return ($signed(a) <= $signed(b)) ? a : b;
    endfunction

    function void note_input(logic kind, logic [55:0] word);
        logic [31:0] value;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        int unsigned start;
        int unsigned lvl;
        int unsigned len;
        value = word[31:0];
        lo = 32'(word[41:32]);
        hi = 32'(word[51:42]);
        if (kind == rmst_pkg::KIND_LOAD) begin
            if (loaded < DEPTH) begin
                window_min[0][loaded] = value;
                for (k = 1; k < NLEVELS && (1 << k) <= loaded + 1; k++) begin
                    start = loaded + 1 - (1 << k);
                    window_min[k][start] = smaller(window_min[k-1][start],
                                                   window_min[k-1][start + (1 << (k-1))]);
                end
                loaded++;
            end
        end
        else if (lo > hi || hi >= loaded) begin
            expected_q.push_back({1'b1, 32'd0});
        end
        else begin
            len = hi - lo + 1;
            lvl = 0;
            while (len > 1) begin
                len = len >> 1;
                lvl++;
            end
            if (lvl >= NLEVELS)
                lvl = NLEVELS - 1;
            expected_q.push_back({1'b0, smaller(window_min[lvl][lo],
                                                window_min[lvl][hi + 1 - (1 << lvl)])});
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [31:0] value, logic err);
        logic [32:0] exp_word;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected word min=%h err=%b", value, err));
        end
        else begin
            exp_word = expected_q.pop_front();
            if (err !== exp_word[32])
                report($sformatf("range_error got %b want %b", err, exp_word[32]));
            if (value !== exp_word[31:0])
                report($sformatf("min_value got %h want %h", value, exp_word[31:0]));
        end
    endtask

    function int pending();
        return expected_q.size();
    endfunction
endclass

module range_minimum_sparse_table_core_test;
    import rmst_pkg::*;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int CYCLE_LIMIT  = 900000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = KIND_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    min_scoreboard #(MAX_ELEMENTS, LEVELS) sb;
    int  cycles = 0;
    int  ready_hold = 0;
    bit  quiet = 1'b0;          // no idling on either side while set
    int  loads_sent = 0;

    range_minimum_sparse_table_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .LEVELS(LEVELS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // sink side back-pressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (quiet || $urandom_range(0, 2) != 0)
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 5);
        end
        else
        begin
            m_tready   <= 1'b0;
            ready_hold <= stall_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 15)) - 32'd8;
            3: return 32'($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    task send_word(logic kind, logic [31:0] value, logic [9:0] lo, logic [9:0] hi);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, hi, lo, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : stall_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task send_load(logic [31:0] value);
        send_word(KIND_LOAD, value, 10'($urandom), 10'($urandom));
        if (loads_sent < MAX_ELEMENTS)
            loads_sent++;
    endtask

    task send_query(int lo, int hi);
        send_word(KIND_QUERY, $urandom, 10'(lo), 10'(hi));
    endtask

    // mostly in-range queries, some arbitrary index pairs
    task send_random_query();
        int hi;
        int lo;
        if (loads_sent == 0 || $urandom_range(0, 4) == 0)
        begin
            send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        else
        begin
            hi = $urandom_range(0, loads_sent - 1);
            case ($urandom_range(0, 3))
                0: lo = hi;
                1: lo = (hi >= 8) ? hi - $urandom_range(0, 7) : 0;
                default: lo = $urandom_range(0, hi);
            endcase
            send_query(lo, hi);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty table, extremes, bad ranges
        send_query(0, 0);
        send_query(1023, 1023);
        send_load(32'h7FFF_FFFF);
        send_load(32'h8000_0000);
        send_load(32'h0000_0000);
        send_load(32'hFFFF_FFFF);
        send_load(32'h0000_0001);
        send_query(0, 0);
        send_query(1, 1);
        send_query(0, 4);
        send_query(2, 4);
        send_query(3, 4);
        send_query(4, 0);       // left above right
        send_query(0, 5);       // right equal to count
        send_query(0, 1023);
        send_query(1023, 0);
        repeat (5) send_load(pick_value());
        send_query(0, 9);
        send_query(5, 9);
        send_query(2, 8);

        // load-heavy mix so the upper table levels get exercised
        for (int i = 0; i < 660; i++)
        begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 80)
                send_load(pick_value());
            else
                send_random_query();
        end
        quiet = 1'b0;

        send_query(0, loads_sent - 1);
        send_query(loads_sent / 2, loads_sent - 1);
        send_query(0, 1023);
        send_query(1, loads_sent - 1);
        send_query(1023, 1023);
        repeat (30) send_random_query();

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> range_minimum_sparse_table_core.f
hw/rtl/rmst_pkg.sv
hw/rtl/rmst_table_mem.sv
hw/rtl/rmst_min_unit.sv
hw/rtl/range_minimum_sparse_table_core.sv
hw/rtl/rmst_checker.sv
test/range_minimum_sparse_table_core_test.sv
